/* design/ifd_pkg.sv */
package ifd_pkg;

   localparam int FRAME_BYTES = 19;
   localparam int POS_BITS = 5;
   localparam int WORD_COUNT = 6;
   localparam int WORD_IDX_BITS = $clog2(WORD_COUNT);

   localparam logic [POS_BITS-1:0] POS_HUNT = POS_BITS'(0);
   localparam logic [POS_BITS-1:0] POS_SECOND = POS_BITS'(1);
   localparam logic [POS_BITS-1:0] POS_SUM_FIRST = POS_BITS'(2);
   localparam logic [POS_BITS-1:0] POS_WORD_FIRST = POS_BITS'(3);
   localparam logic [POS_BITS-1:0] POS_WORD_END = POS_BITS'(3 + 2 * WORD_COUNT);
   localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(FRAME_BYTES - 1);

   localparam logic [7:0] HEADER_RESET = 8'hAA;

   localparam logic STATUS_GOOD = 1'b0;
   localparam logic STATUS_SUM_ERROR = 1'b1;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] time_now;
   } ifd_req_type;

   typedef struct packed {
      logic        status;
      logic [15:0] yaw_raw;
      logic [15:0] pitch_raw;
      logic [15:0] roll_raw;
      logic [15:0] accel_x;
      logic [15:0] accel_y;
      logic [15:0] accel_z;
      logic [31:0] frame_time;
   } ifd_rsp_type;

endpackage

/* design/imu_frame_deframer_unit.sv */
// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_stall     ifd_req_type: rx_byte, time_now
// rsp      out        rsp_valid / rsp_stall     ifd_rsp_type: status, six words, frame_time
// csr      in         csr_write_enable          csr_write_data: header byte
//
// Byte beats are taken at one beat per cycle while req_stall is low.
// The checksum byte of a frame loads the result register; the result is shown the next cycle.
// Bytes that do not end a frame are taken even while a result waits in the result register.
// A checksum byte is held off only while the result register is full and rsp_stall is high.
// Synchronous reset returns the parser to header hunting and empties the result register.
module imu_frame_deframer_unit
   import ifd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ifd_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ifd_rsp_type rsp_payload,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic [7:0]          header_ff;
   logic [POS_BITS-1:0] pos_ff;
   logic [POS_BITS-1:0] pos_in;
   logic [7:0]          sum_ff;
   logic [7:0]          sum_in;
   logic [7:0]          low_hold_ff;
   logic [15:0]         store_ff [WORD_COUNT];
   logic                rsp_valid_ff;
   ifd_rsp_type         rsp_payload_ff;
   ifd_rsp_type         rsp_payload_in;

   logic                accept;
   logic                at_last;
   logic                header_match;
   logic                in_words;
   logic [POS_BITS-1:0] word_off;
   logic [WORD_IDX_BITS-1:0] word_sel;
   logic                sum_good;

   assign at_last = (pos_ff >= POS_LAST);
   assign req_stall = rsp_valid_ff && rsp_stall && at_last;
   assign accept = req_valid && !req_stall;
   assign header_match = (req_payload.rx_byte == header_ff);
   assign word_off = pos_ff - POS_WORD_FIRST;
   assign word_sel = word_off[WORD_IDX_BITS:1];
   assign in_words = (pos_ff >= POS_WORD_FIRST) && (pos_ff < POS_WORD_END);
   assign sum_good = (req_payload.rx_byte == sum_ff);

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (pos_ff == POS_HUNT) begin
         if (header_match) begin
            pos_in = POS_SECOND;
            sum_in = '0;
         end
      end else if (pos_ff == POS_SECOND) begin
         pos_in = header_match ? POS_SUM_FIRST : POS_HUNT;
         sum_in = '0;
      end else if (at_last) begin
         pos_in = POS_HUNT;
         sum_in = '0;
      end else begin
         pos_in = pos_ff + POS_BITS'(1);
         sum_in = sum_ff + req_payload.rx_byte;
      end
   end

   always_comb begin
      rsp_payload_in.status = sum_good ? STATUS_GOOD : STATUS_SUM_ERROR;
      rsp_payload_in.yaw_raw = sum_good ? store_ff[0] : '0;
      rsp_payload_in.pitch_raw = sum_good ? store_ff[1] : '0;
      rsp_payload_in.roll_raw = sum_good ? store_ff[2] : '0;
      rsp_payload_in.accel_x = sum_good ? store_ff[3] : '0;
      rsp_payload_in.accel_y = sum_good ? store_ff[4] : '0;
      rsp_payload_in.accel_z = sum_good ? store_ff[5] : '0;
      rsp_payload_in.frame_time = req_payload.time_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else if (csr_write_enable) begin
         header_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         sum_ff <= '0;
         low_hold_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         if (in_words && !at_last && !word_off[0]) begin
            low_hold_ff <= req_payload.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_words && !at_last && word_off[0]) begin
         store_ff[word_sel] <= {req_payload.rx_byte, low_hold_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && at_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && at_last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("byte position ran past the checksum byte");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept && at_last |=> rsp_valid_ff && pos_ff == POS_HUNT)
      else $error("checksum byte did not load a result and restart hunting");

   a_data_advances: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff >= POS_SUM_FIRST && !at_last |=>
      pos_ff == $past(pos_ff) + POS_BITS'(1))
      else $error("data byte did not advance the byte position");

   a_new_result_from_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall) |->
      $past(accept && at_last))
      else $error("result appeared without a checksum byte");
`endif

endmodule
